/* hw/rtl/mlpcs_pkg.sv */
// ----------------------------------------------------------------------------
// mlpcs_pkg
// Shared types, sizes, weight ROMs and exponent table for the MLP classifier.
// ----------------------------------------------------------------------------
package mlpcs_pkg;

    localparam int FEATURE_COUNT = 5;
    localparam int HIDDEN_COUNT  = 8;
    localparam int CLASS_COUNT   = 4;

    localparam int FEAT_W      = 16;
    localparam int WGT_W       = 16;
    localparam int HID_W       = 23;   // ReLU output, Q.8, never negative
    localparam int MUL_A_W     = 24;
    localparam int LOGIT_W     = 48;   // Q.21 accumulator
    localparam int PROB_W      = 16;
    localparam int CLASS_IDX_W = 2;
    localparam int EXP_W       = 17;   // exp result, Q.16, up to 65536
    localparam int SUM_W       = 19;
    localparam int T_W         = 25;
    localparam int NUM_W       = 34;
    localparam int CNT_W       = 6;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 88;

    typedef logic signed [WGT_W-1:0]   wgt_t;
    typedef logic signed [LOGIT_W-1:0] logit_t;
    typedef logit_t [CLASS_COUNT-1:0]  logit_vec_t;

    typedef enum logic [1:0] {F_IDLE, F_HID, F_OUT, F_PUSH} front_state_t;
    typedef enum logic [2:0] {B_IDLE, B_EXPT, B_EXPE, B_DLOAD, B_DIV, B_OUT} back_state_t;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [PROB_W-1:0] UNIFORM_PROB = PROB_W'(65536 / CLASS_COUNT);

    localparam wgt_t HID_WGT [HIDDEN_COUNT][FEATURE_COUNT] = '{
        '{  16'sd3441, -16'sd9175,   16'sd6963,  16'sd2540,  -16'sd410 },
        '{ -16'sd7291,  16'sd3686,  -16'sd1802,  16'sd8602,  16'sd5243 },
        '{   16'sd983,  16'sd7782, -16'sd11715, -16'sd1229,  16'sd1802 },
        '{  16'sd9011,  16'sd1229,   16'sd2703, -16'sd6717, -16'sd3359 },
        '{ -16'sd2703, -16'sd6144,   16'sd7455,  16'sd3604,  16'sd6717 },
        '{  16'sd5325, -16'sd1802,  -16'sd4997, -16'sd9421,  -16'sd737 },
        '{  -16'sd410,  16'sd9830,   16'sd3686,   16'sd901, -16'sd7537 },
        '{  16'sd6636, -16'sd4506,   -16'sd983,  16'sd5898,  16'sd3686 }
    };

    localparam wgt_t HID_BIAS [HIDDEN_COUNT] = '{
        -16'sd819, 16'sd2048, -16'sd410, 16'sd1229,
        -16'sd1638, 16'sd655, 16'sd983, -16'sd1475
    };

    localparam wgt_t OUT_WGT [CLASS_COUNT][HIDDEN_COUNT] = '{
        '{ 16'sd10240, -16'sd6717,  16'sd3604, -16'sd1229,
           16'sd7537, -16'sd3359,   16'sd901, -16'sd5325 },
        '{ -16'sd7537,  16'sd9421, -16'sd2703,  16'sd6717,
           -16'sd4506,  16'sd5816, -16'sd1802,  16'sd3604 },
        '{  16'sd1229, -16'sd3359, 16'sd10895, -16'sd7537,
           16'sd901,  16'sd8602, -16'sd6717,  16'sd2048 },
        '{ -16'sd4506, -16'sd1802, -16'sd7455,  16'sd9011,
           -16'sd6717, -16'sd1229,  16'sd9421, -16'sd7537 }
    };

    localparam wgt_t OUT_BIAS [CLASS_COUNT] = '{
        16'sd410, -16'sd819, 16'sd1638, -16'sd1229
    };

    // 2^(-k/16), Q.16
    localparam logic [EXP_W-1:0] EXP2_TAB [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

endpackage

/* hw/rtl/mlpcs_front.sv */
// ----------------------------------------------------------------------------
// mlpcs_front
// Input buffer and both dense layers on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module mlpcs_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mlpcs_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            lq_valid,
    input  logic                            lq_ready,
    output mlpcs_pkg::logit_vec_t           lq_data
);
    import mlpcs_pkg::*;

    front_state_t state_reg, state_next;

    logic                 xb_valid_reg;
    logic [S_TDATA_W-1:0] xb_reg;
    logic signed [FEAT_W-1:0] x_reg [FEATURE_COUNT];
    logic [HID_W-1:0]     h_reg [HIDDEN_COUNT];
    logic [2:0]           i_reg, j_reg;
    logit_t               acc_reg;
    logit_vec_t           logit_reg;

    logic                        take;
    logic signed [MUL_A_W-1:0]   mul_a;
    wgt_t                        mul_b;
    logic signed [MUL_A_W+WGT_W-1:0] prod;
    logit_t                      sum, sum_rnd;
    logic                        last_j, last_i;
    logic [2:0]                  i_inc;

    assign s_tready = !xb_valid_reg;
    assign take     = (state_reg == F_IDLE) && xb_valid_reg;
    assign lq_valid = (state_reg == F_PUSH);
    assign lq_data  = logit_reg;
    assign i_inc    = i_reg + 3'd1;

    always_comb
    begin
        if (state_reg == F_OUT)
        begin
            mul_a = $signed({1'b0, h_reg[j_reg]});
            mul_b = OUT_WGT[i_reg[1:0]][j_reg];
        end
        else
        begin
            mul_a = MUL_A_W'(x_reg[j_reg]);
            mul_b = HID_WGT[i_reg][j_reg];
        end
        prod    = mul_a * mul_b;
        sum     = acc_reg + LOGIT_W'(prod);
        sum_rnd = sum + logit_t'(4096);
        last_j  = (state_reg == F_OUT) ? (j_reg == 3'(HIDDEN_COUNT - 1))
                                       : (j_reg == 3'(FEATURE_COUNT - 1));
        last_i  = (state_reg == F_OUT) ? (i_reg == 3'(CLASS_COUNT - 1))
                                       : (i_reg == 3'(HIDDEN_COUNT - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (take) state_next = F_HID;
            F_HID:  if (last_j && last_i) state_next = F_OUT;
            F_OUT:  if (last_j && last_i) state_next = F_PUSH;
            F_PUSH: if (lq_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            xb_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_tvalid && s_tready)
                xb_valid_reg <= 1'b1;
            else if (take)
                xb_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            xb_reg <= s_tdata;
        case (state_reg)
            F_IDLE:
            begin
                for (int k = 0; k < FEATURE_COUNT; k++)
                    x_reg[k] <= xb_reg[k*FEAT_W +: FEAT_W];
                i_reg   <= 3'd0;
                j_reg   <= 3'd0;
                acc_reg <= logit_t'(HID_BIAS[0]) <<< 8;
            end
            F_HID:
            begin
                if (last_j)
                begin
                    h_reg[i_reg] <= (sum > 0) ? sum_rnd[HID_W+12:13] : '0;
                    j_reg <= 3'd0;
                    if (last_i)
                    begin
                        i_reg   <= 3'd0;
                        acc_reg <= logit_t'(OUT_BIAS[0]) <<< 8;
                    end
                    else
                    begin
                        i_reg   <= i_inc;
                        acc_reg <= logit_t'(HID_BIAS[i_inc]) <<< 8;
                    end
                end
                else
                begin
                    j_reg   <= j_reg + 3'd1;
                    acc_reg <= sum;
                end
            end
            F_OUT:
            begin
                if (last_j)
                begin
                    logit_reg[i_reg[1:0]] <= sum;
                    j_reg   <= 3'd0;
                    i_reg   <= i_inc;
                    acc_reg <= logit_t'(OUT_BIAS[i_inc[1:0]]) <<< 8;
                end
                else
                begin
                    j_reg   <= j_reg + 3'd1;
                    acc_reg <= sum;
                end
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/mlpcs_queue.sv */
// ----------------------------------------------------------------------------
// mlpcs_queue
// Two-entry logit queue between the layer engine and the softmax engine.
// ----------------------------------------------------------------------------
module mlpcs_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mlpcs_pkg::logit_vec_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mlpcs_pkg::logit_vec_t out_data
);
    import mlpcs_pkg::*;

    logit_vec_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_data;
    end

endmodule

/* hw/rtl/mlpcs_back.sv */
// ----------------------------------------------------------------------------
// mlpcs_back
// Softmax: max, table exponent, serial divide, argmax and output register.
// ----------------------------------------------------------------------------
module mlpcs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            lq_valid,
    output logic                            lq_ready,
    input  mlpcs_pkg::logit_vec_t           lq_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mlpcs_pkg::M_TDATA_W-1:0] m_tdata
);
    import mlpcs_pkg::*;

    back_state_t state_reg, state_next;

    logit_vec_t           l_reg;
    logit_t               mx_reg;
    logic [1:0]           c_reg;
    logic [T_W-1:0]       t_reg;
    logic [EXP_W-1:0]     e_reg [CLASS_COUNT];
    logic [SUM_W-1:0]     sum_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [PROB_W-1:0]    p_reg [CLASS_COUNT];
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logit_t            mx_in, diff;
    logic [23:0]       d24;
    logic [40:0]       t_prod;
    logic [8:0]        n;
    logic [4:0]        k;
    logic [EXP_W-1:0]  tab_a, tab_b, tab_d, v, e_val;
    logic [28:0]       interp;
    logic [SUM_W:0]    rem_sh;
    logic              ge;
    logic [NUM_W-1:0]  quo;
    logic [PROB_W-1:0] p_val, best_p;
    logic [1:0]        best;
    logic              last_c, load_out;

    assign lq_ready = (state_reg == B_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign last_c   = (c_reg == 2'(CLASS_COUNT - 1));
    assign load_out = (state_reg == B_OUT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        mx_in = lq_data[0];
        for (int i = 1; i < CLASS_COUNT; i++)
            if ($signed(lq_data[i]) > $signed(mx_in))
                mx_in = lq_data[i];

        // exp(-d): d*log2(e) split into shift and table fraction
        diff   = mx_reg - l_reg[c_reg];
        d24    = (|diff[LOGIT_W-1:29]) ? 24'hFFFFFF : diff[28:5];
        t_prod = 41'(d24) * 41'(LOG2E_Q16) + 41'd32768;
        n      = t_reg[T_W-1:16];
        k      = {1'b0, t_reg[15:12]};
        tab_a  = EXP2_TAB[k];
        tab_b  = EXP2_TAB[k + 5'd1];
        tab_d  = tab_a - tab_b;
        interp = 29'(tab_d[11:0]) * 29'(t_reg[11:0]) + 29'd2048;
        v      = tab_a - EXP_W'(interp[28:12]);
        e_val  = (n >= 9'd17) ? '0 : (v >> n[4:0]);

        // one restoring divide step
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        ge     = (rem_sh >= {1'b0, sum_reg});
        quo    = {num_reg[NUM_W-2:0], ge};
        if (sum_reg == '0)
            p_val = UNIFORM_PROB;
        else if (|quo[NUM_W-1:PROB_W])
            p_val = '1;
        else
            p_val = quo[PROB_W-1:0];

        best   = 2'd0;
        best_p = p_reg[0];
        for (int i = 1; i < CLASS_COUNT; i++)
            if (p_reg[i] > best_p)
            begin
                best_p = p_reg[i];
                best   = 2'(i);
            end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (lq_valid) state_next = B_EXPT;
            B_EXPT:  state_next = B_EXPE;
            B_EXPE:  state_next = last_c ? B_DLOAD : B_EXPT;
            B_DLOAD: state_next = B_DIV;
            B_DIV:   if (cnt_reg == CNT_W'(NUM_W - 1))
                         state_next = last_c ? B_OUT : B_DLOAD;
            B_OUT:   if (load_out) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                l_reg   <= lq_data;
                mx_reg  <= mx_in;
                c_reg   <= 2'd0;
                sum_reg <= '0;
            end
            B_EXPT:
                t_reg <= t_prod[40:16];
            B_EXPE:
            begin
                e_reg[c_reg] <= e_val;
                sum_reg      <= sum_reg + SUM_W'(e_val);
                c_reg        <= c_reg + 2'd1;
            end
            B_DLOAD:
            begin
                num_reg <= {1'b0, e_reg[c_reg], 16'd0} + NUM_W'(sum_reg >> 1);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            B_DIV:
            begin
                rem_reg <= ge ? SUM_W'(rem_sh - {1'b0, sum_reg}) : rem_sh[SUM_W-1:0];
                num_reg <= quo;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    p_reg[c_reg] <= p_val;
                    c_reg        <= c_reg + 2'd1;
                end
            end
            default: ;
        endcase
        if (load_out)
            m_tdata_reg <= {6'd0, best_p, best, p_reg[3], p_reg[2], p_reg[1], p_reg[0]};
    end

endmodule

/* hw/rtl/mlp_classifier_softmax_argmax.sv */
// ----------------------------------------------------------------------------
// mlp_classifier_softmax_argmax
// Two-layer perceptron (5-8-4, ReLU) with fixed-point softmax and argmax.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata: feature_0..feature_4
//  m_*      out  m_tvalid/m_tready   m_tdata: prob_0..3, top_class, confidence
//
//  Layer engine: one shared MAC runs the hidden, then the output layer;
//  a new vector is buffered meanwhile, and the logits wait for the queue.
//  Softmax engine: takes a vector, finds each class exponent, runs a
//  bit-serial divide per class, then loads the output register.
//  The two engines run on different vectors; a two-entry queue sits between.
//  rst_n clears control state asynchronously; a stalled output holds.
// ----------------------------------------------------------------------------
module mlp_classifier_softmax_argmax (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // feature_0 [15:0] .. feature_4 [79:64], signed Q7.8
    input  logic [mlpcs_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // prob_0 [15:0], prob_1, prob_2, prob_3 [63:48], top_class [65:64],
    // confidence [81:66], zero pad [87:82]
    output logic [mlpcs_pkg::M_TDATA_W-1:0] m_tdata
);
    import mlpcs_pkg::*;

    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    logit_vec_t fq_data, qb_data;

    mlpcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .lq_valid (fq_valid),
        .lq_ready (fq_ready),
        .lq_data  (fq_data)
    );

    mlpcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    mlpcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .lq_valid (qb_valid),
        .lq_ready (qb_ready),
        .lq_data  (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    // confidence is the probability at top_class
    a_conf_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[65:64] == 2'd0 && m_tdata[81:66] == m_tdata[15:0]) ||
                      (m_tdata[65:64] == 2'd1 && m_tdata[81:66] == m_tdata[31:16]) ||
                      (m_tdata[65:64] == 2'd2 && m_tdata[81:66] == m_tdata[47:32]) ||
                      (m_tdata[65:64] == 2'd3 && m_tdata[81:66] == m_tdata[63:48])))
        else $error("confidence does not match top_class");

    // confidence is the largest probability
    a_conf_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[81:66] >= m_tdata[15:0] && m_tdata[81:66] >= m_tdata[31:16] &&
                      m_tdata[81:66] >= m_tdata[47:32] && m_tdata[81:66] >= m_tdata[63:48]))
        else $error("confidence below some probability");

    // a stalled output transaction holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while stalled");
`endif

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MLP classifier: feature vectors are streamed in
// with random gaps, results are predicted in fixed point and compared per field.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mlpcs_pkg::*;

    localparam int N_RANDOM   = 1130;
    localparam int CYCLE_MAX  = 1500000;   // well over the run time of all vectors plus stalls
    localparam int DRAIN_WAIT = 400;

    typedef struct packed {
        logic [15:0] confidence;
        logic [1:0]  top_class;
        logic [15:0] prob_3;
        logic [15:0] prob_2;
        logic [15:0] prob_1;
        logic [15:0] prob_0;
    } class_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    logic [S_TDATA_W-1:0]   vector_queue [$];
    class_result_t          result_queue [$];

    int  mismatch_count;
    int  result_count;
    int  vector_count;
    int  cycle_count;
    int  send_wait;
    int  recv_wait;
    int  hold_off;
    bit  hold_done;
    bit  stim_done;

    mlp_classifier_softmax_argmax dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // exp(-d) for a non-negative Q.21 difference, result Q.16
    function automatic logic [16:0] neg_exp_q16(input logic [63:0] diff);
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] frac;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] v;
        int          k;
        d = diff >> 5;
        if (d > 64'hFF_FFFF)
        begin
            d = 64'hFF_FFFF;
        end
        t = (d * 64'd94548 + 64'd32768) >> 16;
        n = t >> 16;
        if (n >= 17)
        begin
            return 17'd0;
        end
        frac = t & 64'hFFFF;
        k    = int'(frac >> 12);
        lo   = EXP2_TAB[k];
        hi   = EXP2_TAB[k + 1];
        v    = lo - (((lo - hi) * (frac & 64'hFFF) + 64'd2048) >> 12);
        return 17'(v >> n);
    endfunction

    function automatic class_result_t classify(input logic [S_TDATA_W-1:0] feat);
        longint        x [FEATURE_COUNT];
        longint        h [HIDDEN_COUNT];
        longint        logit [CLASS_COUNT];
        longint        acc;
        longint        top;
        logic [63:0]   e [CLASS_COUNT];
        logic [63:0]   q [CLASS_COUNT];
        logic [63:0]   sum;
        logic [63:0]   best_p;
        int            best;
        class_result_t r;
        for (int j = 0; j < FEATURE_COUNT; j++)
        begin
            x[j] = longint'($signed(feat[16*j +: 16]));
        end
        for (int i = 0; i < HIDDEN_COUNT; i++)
        begin
            acc = longint'(HID_BIAS[i]) * 256;
            for (int j = 0; j < FEATURE_COUNT; j++)
            begin
                acc += x[j] * longint'(HID_WGT[i][j]);
            end
            h[i] = (acc > 0) ? ((acc + 4096) >>> 13) : 0;
        end
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            acc = longint'(OUT_BIAS[i]) * 256;
            for (int j = 0; j < HIDDEN_COUNT; j++)
            begin
                acc += h[j] * longint'(OUT_WGT[i][j]);
            end
            logit[i] = acc;
        end
        top = logit[0];
        for (int i = 1; i < CLASS_COUNT; i++)
        begin
            if (logit[i] > top)
            begin
                top = logit[i];
            end
        end
        sum = 0;
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            e[i] = 64'(neg_exp_q16(64'(top - logit[i])));
            sum += e[i];
        end
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            // zero sum is unreachable, uniform fallback kept for completeness
            q[i] = (sum != 0) ? (e[i] * 65536 + sum / 2) / sum : 64'(UNIFORM_PROB);
            if (q[i] > 65535)
            begin
                q[i] = 65535;
            end
        end
        // first largest wins on ties
        best   = 0;
        best_p = q[0];
        for (int i = 1; i < CLASS_COUNT; i++)
        begin
            if (q[i] > best_p)
            begin
                best_p = q[i];
                best   = i;
            end
        end
        r.prob_0     = q[0][15:0];
        r.prob_1     = q[1][15:0];
        r.prob_2     = q[2][15:0];
        r.prob_3     = q[3][15:0];
        r.top_class  = 2'(best);
        r.confidence = best_p[15:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_feature(input int mode);
        case (mode)
            0:       return 16'(-$urandom_range(1024, 0));     // near-zero, negative
            1:       return 16'($urandom_range(1024, 0));
            2:       return 16'($urandom_range(2047, 0) - 1024);
            3:       return 16'(32767 - $urandom_range(15, 0));
            4:       return 16'(16'h8000 + $urandom_range(15, 0));
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus: directed corners, then random vectors of mixed magnitude
    initial
    begin
        logic [S_TDATA_W-1:0] v;
        int                   mode;
        vector_queue.push_back('0);
        vector_queue.push_back({5{16'h7FFF}});
        vector_queue.push_back({5{16'h8000}});
        vector_queue.push_back({5{16'hFFFF}});
        vector_queue.push_back({5{16'h0001}});
        vector_queue.push_back({5{16'h0100}});
        vector_queue.push_back({5{16'hFF00}});
        for (int j = 0; j < FEATURE_COUNT; j++)
        begin
            // one feature at each extreme and at 0x0400, rest zero: drives single classes to win
            v = '0;
            v[16*j +: 16] = 16'h7FFF;
            vector_queue.push_back(v);
            v[16*j +: 16] = 16'h8000;
            vector_queue.push_back(v);
            v[16*j +: 16] = 16'h0400;
            vector_queue.push_back(v);
        end
        vector_queue.push_back({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        vector_queue.push_back({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        vector_queue.push_back({5{16'h5555}});
        vector_queue.push_back({5{16'hAAAA}});
        for (int n = 0; n < N_RANDOM; n++)
        begin
            mode = $urandom_range(7, 0);
            for (int j = 0; j < FEATURE_COUNT; j++)
            begin
                // small values keep softmax non-saturated most of the time
                v[16*j +: 16] = pick_feature((mode < 2) ? 2 : $urandom_range(7, 0));
            end
            vector_queue.push_back(v);
        end
        stim_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: one transaction at a time from the vector queue, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                result_queue.push_back(classify(s_tdata));
                vector_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_wait > 0)
                begin
                    s_tvalid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (vector_queue.size() > 0)
                begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= vector_queue.pop_front();
                    send_wait <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 0);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long hold-off: once, after 300 results, the receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
        end
        else if (!hold_done && result_count >= 300)
        begin
            // the inner queue fills and s_tready drops
            hold_off  <= 2000;
            hold_done <= 1'b1;
        end
    end

    // receiver ready: random stall per transaction (none between results 600 and 700), held low during the hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end
        else if (hold_off > 0)
        begin
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            m_tready  <= 1'b0;
            recv_wait <= (result_count > 600 && result_count < 700) ? 0
                         : $urandom_range(5, 0);
        end
        else if (recv_wait > 0)
        begin
            m_tready  <= 1'b0;
            recv_wait <= recv_wait - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // monitor: compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        class_result_t got;
        class_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = class_result_t'(m_tdata[81:0]);
            result_count++;
            if (result_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result transaction %h", m_tdata);
                end
            end
            else
            begin
                want = result_queue.pop_front();
                if (got != want || m_tdata[87:82] != '0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result %0d: expected p=%h %h %h %h cls=%0d conf=%h",
                                 result_count, want.prob_0, want.prob_1, want.prob_2,
                                 want.prob_3, want.top_class, want.confidence);
                        $display("result %0d: actual   p=%h %h %h %h cls=%0d conf=%h pad=%h",
                                 result_count, got.prob_0, got.prob_1, got.prob_2,
                                 got.prob_3, got.top_class, got.confidence,
                                 m_tdata[87:82]);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_MAX)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        result_count   = 0;
        vector_count   = 0;
        cycle_count    = 0;
        @(posedge rst_n);
        while (!stim_done || vector_queue.size() != 0 || s_tvalid ||
               result_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (result_queue.size() != 0)
        begin
            mismatch_count++;
        end
        $display("%0d feature vectors sent, %0d classifications checked, %0d mismatches",
                 vector_count, result_count, mismatch_count);
        $display("covered field extremes, random magnitudes, gaps and long back-pressure");
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/mlpcs_pkg.sv
hw/rtl/mlpcs_front.sv
hw/rtl/mlpcs_queue.sv
hw/rtl/mlpcs_back.sv
hw/rtl/mlp_classifier_softmax_argmax.sv
dv/testbench.sv
